// File: rtl/core/sltr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the sta/lta trigger ratio core
package sltr_pkg;

	// width of the running sums of squares, they wrap modulo 2^SUM_W
	localparam int SUM_W     = 59;
	// fraction bits of the ratio and quotient width of the divider
	localparam int FRAC_BITS = 16;
	localparam int Q_BITS    = 29;
	localparam int QCNT_W    = $clog2(Q_BITS);
	// saturation value of the ratio, 4096.0 in Q13.16
	localparam logic [Q_BITS-1:0] RATIO_CAP = Q_BITS'(32'h1000_0000);
	// operand width of the shared multiplier
	localparam int MUL_W     = 32;

	// configuration port
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_STA_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LTA_LEN = 2'd1;
	localparam logic [CFG_W-1:0] STA_RESET = 13'd50;
	localparam logic [CFG_W-1:0] LTA_RESET = 13'd1000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_S,
		ST_RD_L,
		ST_SUB_S,
		ST_SUB_L,
		ST_MUL_SL,
		ST_MUL_SH,
		ST_MUL_LL,
		ST_MUL_LH,
		ST_DEN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: rtl/core/sltr_if.sv
`timescale 1ns / 1ps
// handshake channels of the sta/lta trigger ratio core: samples, results, configuration
interface sltr_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          first;
	logic                          last;

	modport source (output valid, output sample, output first, output last, input ready);
	modport sink   (input valid, input sample, input first, input last, output ready);
endinterface

interface sltr_out_if;
	logic                            valid;
	logic                            ready;
	logic [sltr_pkg::Q_BITS-1:0]     ratio;
	logic                            warmed_up;
	logic                            short_record;

	modport source (output valid, output ratio, output warmed_up, output short_record,
		input ready);
	modport sink   (input valid, input ratio, input warmed_up, input short_record,
		output ready);
endinterface

interface sltr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [sltr_pkg::CFG_IDX_W-1:0]    index;
	logic [sltr_pkg::CFG_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/sta_lta_trigger_ratio_core.sv
`timescale 1ns / 1ps
// top level of the sta/lta trigger ratio core
// Takes one signed sample per transfer and returns one result per sample: the
// classic sta/lta characteristic function (short energy / sta_len) over
// (long energy / lta_len) in unsigned Q13.16, truncated and saturated at 4096.0,
// plus a warm-up flag and a short-record flag on the last sample of a record.
// Energies are exact running sums of squares kept against a history ram of
// MAX_WINDOW samples; the ratio comes from one 32x32 multiplier (squares and
// partial products) and a restoring divider that yields one quotient bit per
// cycle. Once the record is warmed up, a sample goes through history reads,
// squares, sum updates and partial products, then the divider (an overflow
// check, 29 quotient steps and the hand-over of the quotient), and last the
// load of the output register. A saturated ratio leaves the divider right
// after the check; during warm-up or with zero long-term energy the divider
// is skipped. The core takes one sample at a time; a finished result sits in
// an output register so the next sample can be taken before the result is,
// and a result held back by the receiver adds its stall cycles to the sample
// behind it. The history ram needs no clearing after reset, the sums and the
// sample count start at zero.
module sta_lta_trigger_ratio_core #(
	parameter int MAX_WINDOW  = 4096,
	parameter int SAMPLE_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	sltr_cfg_if.sink    cfg,
	sltr_in_if.sink     samples,
	sltr_out_if.source  results
);

	localparam int AW     = $clog2(MAX_WINDOW);
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = sltr_pkg::SUM_W;
	localparam int PROD_W = SUM_W + CNT_W;
	localparam int NUM_W  = PROD_W + sltr_pkg::FRAC_BITS;
	localparam int MW     = sltr_pkg::MUL_W;

	// configuration registers
	logic [sltr_pkg::CFG_W-1:0] sta_len_q;
	logic [sltr_pkg::CFG_W-1:0] lta_len_q;

	// sequencer and record state
	sltr_pkg::state_t state_q, state_d;
	logic [SUM_W-1:0] short_sum_q;
	logic [SUM_W-1:0] long_sum_q;
	logic [CNT_W-1:0] count_q;
	logic [AW-1:0]    wp_q;
	logic             out_valid_q;

	// per-sample working registers
	logic [SAMPLE_BITS-1:0]      sample_q;
	logic                        last_q;
	logic [CNT_W-1:0]            s_eff_q;
	logic [CNT_W-1:0]            l_eff_q;
	logic [PROD_W-1:0]           num_q;
	logic [PROD_W-1:0]           den_q;
	logic [sltr_pkg::Q_BITS-1:0] ratio_q;
	logic                        warm_q;
	logic [sltr_pkg::Q_BITS-1:0] out_ratio_q;
	logic                        out_warm_q;
	logic                        out_short_q;

	// effective window lengths
	logic [31:0]      sta32, lta32, s_eff32, l_eff32;
	logic [CNT_W-1:0] s_eff, l_eff;

	// control from the sequencer
	logic             in_ready;
	logic             ram_we;
	logic             div_start;
	logic             out_load;
	logic             use_long;
	logic [MW-1:0]    mul_a, mul_b;

	// datapath
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic [SAMPLE_BITS-1:0] mag_src, mag;
	logic [2*MW-1:0]        mul_p;
	logic [SUM_W-1:0]       sq;
	logic [CNT_W-1:0]       len_sel;
	logic [CNT_W:0]         back;
	logic [AW-1:0]          rd_addr;
	logic                   warm;
	logic                   do_transfer;
	sltr_pkg::div_stat_t    div_stat;
	logic [sltr_pkg::Q_BITS-1:0] div_quo;

	// configuration writes, always accepted
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sta_len_q <= sltr_pkg::STA_RESET;
			lta_len_q <= sltr_pkg::LTA_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				sltr_pkg::REG_STA_LEN: sta_len_q <= cfg.data;
				sltr_pkg::REG_LTA_LEN: lta_len_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// zero acts as one, too long acts as the history depth, short never exceeds long
	always_comb begin
		sta32   = 32'(sta_len_q);
		lta32   = 32'(lta_len_q);
		s_eff32 = (sta32 == 32'd0) ? 32'd1 : ((sta32 > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : sta32);
		l_eff32 = (lta32 == 32'd0) ? 32'd1 : ((lta32 > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : lta32);
		if (s_eff32 > l_eff32) begin
			s_eff32 = l_eff32;
		end
		s_eff = CNT_W'(s_eff32);
		l_eff = CNT_W'(l_eff32);
	end

	// warm once the record holds at least the long window
	assign warm = (count_q >= l_eff_q);

	// output register can take a new result this cycle
	assign do_transfer = !out_valid_q || results.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sltr_pkg::ST_IDLE:     if (samples.valid) state_d = sltr_pkg::ST_RD_S;
			sltr_pkg::ST_RD_S:     state_d = sltr_pkg::ST_RD_L;
			sltr_pkg::ST_RD_L:     state_d = sltr_pkg::ST_SUB_S;
			sltr_pkg::ST_SUB_S:    state_d = sltr_pkg::ST_SUB_L;
			sltr_pkg::ST_SUB_L:    state_d = sltr_pkg::ST_MUL_SL;
			sltr_pkg::ST_MUL_SL: begin
				// no ratio during warm-up or without long-term energy
				if (!warm || long_sum_q == '0) begin
					state_d = sltr_pkg::ST_FINISH;
				end else begin
					state_d = sltr_pkg::ST_MUL_SH;
				end
			end
			sltr_pkg::ST_MUL_SH:   state_d = sltr_pkg::ST_MUL_LL;
			sltr_pkg::ST_MUL_LL:   state_d = sltr_pkg::ST_MUL_LH;
			sltr_pkg::ST_MUL_LH:   state_d = sltr_pkg::ST_DEN;
			sltr_pkg::ST_DEN:      state_d = sltr_pkg::ST_DIV_GO;
			sltr_pkg::ST_DIV_GO:   state_d = sltr_pkg::ST_DIV_WAIT;
			sltr_pkg::ST_DIV_WAIT: if (div_stat.done) state_d = sltr_pkg::ST_FINISH;
			sltr_pkg::ST_FINISH:   if (do_transfer) state_d = sltr_pkg::ST_IDLE;
			default:               state_d = sltr_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		use_long  = 1'b1;
		mul_a     = 32'(mag);
		mul_b     = 32'(mag);
		case (state_q)
			sltr_pkg::ST_IDLE:   in_ready = 1'b1;
			// read the sample leaving the short window, square the new one
			sltr_pkg::ST_RD_S:   use_long = 1'b0;
			sltr_pkg::ST_SUB_S:  ram_we = 1'b1;
			sltr_pkg::ST_MUL_SL: begin
				mul_a = short_sum_q[MW-1:0];
				mul_b = 32'(l_eff_q);
			end
			sltr_pkg::ST_MUL_SH: begin
				mul_a = 32'(short_sum_q[SUM_W-1:MW]);
				mul_b = 32'(l_eff_q);
			end
			sltr_pkg::ST_MUL_LL: begin
				mul_a = long_sum_q[MW-1:0];
				mul_b = 32'(s_eff_q);
			end
			sltr_pkg::ST_MUL_LH: begin
				mul_a = 32'(long_sum_q[SUM_W-1:MW]);
				mul_b = 32'(s_eff_q);
			end
			sltr_pkg::ST_DIV_GO: div_start = 1'b1;
			sltr_pkg::ST_FINISH: out_load = do_transfer;
			default: ;
		endcase
	end

	assign samples.ready = in_ready;

	// history address of the sample that leaves a window, wrapped around the ring
	always_comb begin
		len_sel = use_long ? l_eff_q : s_eff_q;
		back    = {1'b0, CNT_W'(wp_q)} - {1'b0, len_sel};
		if (back[CNT_W]) begin
			back = back + (CNT_W + 1)'(MAX_WINDOW);
		end
		rd_addr = back[AW-1:0];
	end

	sltr_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (sample_q),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// magnitude of the new sample or of a sample read back from history
	always_comb begin
		mag_src = (state_q == sltr_pkg::ST_RD_S) ? sample_q : ram_rdata;
		mag     = mag_src[SAMPLE_BITS-1] ? (~mag_src + 1'b1) : mag_src;
	end

	sltr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign sq = mul_p[SUM_W-1:0];

	sltr_div #(
		.NUM_W (NUM_W),
		.DEN_W (PROD_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({num_q, {sltr_pkg::FRAC_BITS{1'b0}}}),
		.den    (den_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// sequencer state, sums, count, write pointer, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sltr_pkg::ST_IDLE;
			short_sum_q <= '0;
			long_sum_q  <= '0;
			count_q     <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				sltr_pkg::ST_IDLE: begin
					// first sample of a record starts from empty sums
					if (samples.valid && samples.first) begin
						short_sum_q <= '0;
						long_sum_q  <= '0;
						count_q     <= '0;
					end
				end
				sltr_pkg::ST_RD_L: begin
					short_sum_q <= short_sum_q + sq;
					long_sum_q  <= long_sum_q + sq;
				end
				sltr_pkg::ST_SUB_S: begin
					if (count_q >= s_eff_q) begin
						short_sum_q <= short_sum_q - sq;
					end
					wp_q <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
				end
				sltr_pkg::ST_SUB_L: begin
					if (count_q >= l_eff_q) begin
						long_sum_q <= long_sum_q - sq;
					end
					if (count_q < CNT_W'(MAX_WINDOW)) begin
						count_q <= count_q + 1'b1;
					end
				end
				sltr_pkg::ST_FINISH: begin
					// a record ends after its last sample
					if (out_load && last_q) begin
						short_sum_q <= '0;
						long_sum_q  <= '0;
						count_q     <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// working and output payload registers
	always_ff @(posedge clk) begin
		if (in_ready && samples.valid) begin
			sample_q <= samples.sample;
			last_q   <= samples.last;
			s_eff_q  <= s_eff;
			l_eff_q  <= l_eff;
		end
		case (state_q)
			sltr_pkg::ST_MUL_SL: begin
				warm_q  <= warm;
				ratio_q <= '0;
			end
			// numerator short_sum * lta, denominator long_sum * sta, from two halves each
			sltr_pkg::ST_MUL_SH: num_q <= PROD_W'(mul_p);
			sltr_pkg::ST_MUL_LL: num_q <= num_q + (PROD_W'(mul_p) << MW);
			sltr_pkg::ST_MUL_LH: den_q <= PROD_W'(mul_p);
			sltr_pkg::ST_DEN:    den_q <= den_q + (PROD_W'(mul_p) << MW);
			sltr_pkg::ST_DIV_WAIT: begin
				if (div_stat.done) begin
					ratio_q <= div_quo;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_ratio_q <= ratio_q;
			out_warm_q  <= warm_q;
			out_short_q <= last_q && !warm_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.ratio        = out_ratio_q;
	assign results.warmed_up    = out_warm_q;
	assign results.short_record = out_short_q;

`ifndef SYNTH
	// one sample in flight: after a transfer in, no other is taken next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> !samples.ready)
		else $error("sample taken while another is in flight");

	// the divider reports completion only while the sequencer waits for it
	a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == sltr_pkg::ST_DIV_WAIT))
		else $error("divider done outside its wait state");

	// a nonzero ratio only comes from a warmed up record
	a_ratio_needs_warm: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ratio != '0) |-> results.warmed_up)
		else $error("nonzero ratio during warm-up");

	// the sample count saturates at the history depth
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_WINDOW))
		else $error("record count beyond history depth");
`endif

endmodule

// File: rtl/core/sltr_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module sltr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/sltr_mul.sv
`timescale 1ns / 1ps
// shared unsigned multiplier with registered product
module sltr_mul (
	input  logic                         clk,
	input  logic [sltr_pkg::MUL_W-1:0]   a,
	input  logic [sltr_pkg::MUL_W-1:0]   b,
	output logic [2*sltr_pkg::MUL_W-1:0] p
);

	logic [2*sltr_pkg::MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// File: rtl/core/sltr_div.sv
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle, saturating quotient
module sltr_div #(
	parameter int NUM_W = 88,
	parameter int DEN_W = 72
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NUM_W-1:0]             num,
	input  logic [DEN_W-1:0]             den,
	output sltr_pkg::div_stat_t          stat,
	output logic [sltr_pkg::Q_BITS-1:0]  quo
);

	localparam int QB = sltr_pkg::Q_BITS;

	logic [DEN_W-1:0]             r_q;
	logic [QB-1:0]                low_q;
	logic [DEN_W-1:0]             den_q;
	logic [QB-1:0]                q_q;
	logic [sltr_pkg::QCNT_W-1:0]  cnt_q;
	logic                         chk_q;
	logic                         busy_q;
	logic                         done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] opnd;
	logic [DEN_W:0] diff;
	logic           ge;
	logic [QB-1:0]  q_next;

	// one subtractor serves the overflow check and every restoring step
	always_comb begin
		trial  = {r_q, low_q[QB-1]};
		opnd   = chk_q ? {1'b0, r_q} : trial;
		diff   = opnd - {1'b0, den_q};
		ge     = !diff[DEN_W];
		q_next = {q_q[QB-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			chk_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				chk_q  <= 1'b1;
				cnt_q  <= sltr_pkg::QCNT_W'(QB - 1);
			end else if (busy_q) begin
				if (chk_q) begin
					// quotient would not fit, finish at once with the cap
					if (ge) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					chk_q <= 1'b0;
				end else if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= DEN_W'(num[NUM_W-1:QB]);
			low_q <= num[QB-1:0];
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			if (chk_q) begin
				if (ge) begin
					q_q <= sltr_pkg::RATIO_CAP;
				end
			end else begin
				r_q   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				low_q <= {low_q[QB-2:0], 1'b0};
				if (cnt_q == '0 && q_next > sltr_pkg::RATIO_CAP) begin
					q_q <= sltr_pkg::RATIO_CAP;
				end else begin
					q_q <= q_next;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = q_q;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the sta/lta trigger ratio core with its own ratio predictor
module tb;

	localparam int MAX_WINDOW  = 4096;
	localparam int SAMPLE_BITS = 24;
	// generous ceiling on the whole run, far above the slowest legal run
	localparam longint TIMEOUT_NS = 64'd5_000_000;
	// length of the long receiver hold-off and spacing between them in results
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_EVERY  = 500;
	localparam int RANDOM_SAMPLES = 1300;

	// one sample transfer as queued for the driver
	typedef struct {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   first;
		logic                   last;
	} sample_item_t;

	// one result transfer
	typedef struct packed {
		logic [sltr_pkg::Q_BITS-1:0] ratio;
		logic                        warmed_up;
		logic                        short_record;
	} trig_result_t;

	// shape of the samples within one record
	typedef enum {
		SIG_NOISE,
		SIG_EVENT,
		SIG_EXTREME,
		SIG_QUIET,
		SIG_FULL
	} signal_kind_t;

	logic clk;
	logic arst_n;

	sltr_cfg_if                           cfg_ch ();
	sltr_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
	sltr_out_if                           out_ch ();

	sta_lta_trigger_ratio_core #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.samples(in_ch),
		.results(out_ch)
	);

	// samples waiting to be offered, expected results waiting to come out
	sample_item_t sample_pend_q[$];
	trig_result_t ratio_expect_q[$];

	// predictor copy of the window registers and the core's running state
	logic [sltr_pkg::CFG_W-1:0] sta_cfg = sltr_pkg::STA_RESET;
	logic [sltr_pkg::CFG_W-1:0] lta_cfg = sltr_pkg::LTA_RESET;
	bit [SAMPLE_BITS-1:0]       hist_mem [0:MAX_WINDOW-1];
	bit [sltr_pkg::SUM_W-1:0]   short_energy = '0;
	bit [sltr_pkg::SUM_W-1:0]   long_energy  = '0;
	int unsigned                rec_count = 0;
	int unsigned                wr_ptr    = 0;

	// handshake pacing
	bit  no_idle      = 0;
	bit  in_taken     = 0;
	int  in_gap       = 0;
	int  out_stall    = 0;
	int  hold_left    = 0;
	int  next_hold_at = 200;

	// bookkeeping
	int mismatch_cnt = 0;
	int results_seen = 0;
	int accepted_cnt = 0;
	int warm_cnt     = 0;
	int short_cnt    = 0;
	int sat_cnt      = 0;
	int hold_cnt     = 0;
	int cfg_writes   = 0;
	int setting_cnt  = 0;

	// window length as the core uses it: zero acts as one, capped at the ram depth
	function automatic int unsigned eff_len(logic [sltr_pkg::CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_WINDOW)
			return MAX_WINDOW;
		return 32'(v);
	endfunction

	// square of a two's complement sample, exact
	function automatic bit [sltr_pkg::SUM_W-1:0] energy_of(bit [SAMPLE_BITS-1:0] raw);
		bit [SAMPLE_BITS-1:0] mag;
		mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
		return sltr_pkg::SUM_W'(mag) * sltr_pkg::SUM_W'(mag);
	endfunction

	// advance the predicted state by one sample and return its expected result
	function automatic trig_result_t trigger_predict(bit [SAMPLE_BITS-1:0] raw, bit first,
		bit last);
		int unsigned    l_eff;
		int unsigned    s_eff;
		bit [127:0]     num;
		bit [127:0]     den;
		bit [127:0]     quo;
		trig_result_t   r;
		l_eff = eff_len(lta_cfg);
		s_eff = eff_len(sta_cfg);
		// short window never longer than the long one
		if (s_eff > l_eff)
			s_eff = l_eff;
		if (first) begin
			short_energy = '0;
			long_energy  = '0;
			rec_count    = 0;
		end
		short_energy = short_energy + energy_of(raw);
		long_energy  = long_energy + energy_of(raw);
		// drop the sample that leaves each window, sums wrap at SUM_W bits
		if (rec_count >= s_eff)
			short_energy = short_energy
				- energy_of(hist_mem[(wr_ptr + MAX_WINDOW - s_eff) % MAX_WINDOW]);
		if (rec_count >= l_eff)
			long_energy = long_energy
				- energy_of(hist_mem[(wr_ptr + MAX_WINDOW - l_eff) % MAX_WINDOW]);
		hist_mem[wr_ptr] = raw;
		wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
		if (rec_count < MAX_WINDOW)
			rec_count++;

		r.warmed_up = (rec_count >= l_eff);
		r.ratio     = '0;
		// (short/s_len)/(long/l_len) in Q13.16 as one exact integer division
		if (r.warmed_up && long_energy != 0) begin
			num = (128'(short_energy) * 128'(l_eff)) << sltr_pkg::FRAC_BITS;
			den = 128'(long_energy) * 128'(s_eff);
			if (num >= (den << sltr_pkg::Q_BITS)) begin
				r.ratio = sltr_pkg::RATIO_CAP;
			end else begin
				quo = num / den;
				r.ratio = (quo > sltr_pkg::RATIO_CAP) ? sltr_pkg::RATIO_CAP
					: quo[sltr_pkg::Q_BITS-1:0];
			end
		end
		r.short_record = last && !r.warmed_up;
		// a record ends after its last sample even without a following first
		if (last) begin
			short_energy = '0;
			long_energy  = '0;
			rec_count    = 0;
		end
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// sample value of the given shape, k sets the magnitude in bits
	function automatic logic [SAMPLE_BITS-1:0] rand_sample(signal_kind_t kind, int k);
		logic [SAMPLE_BITS-1:0] m;
		m = SAMPLE_BITS'($urandom) >> (SAMPLE_BITS - 1 - k);
		if ($urandom_range(0, 1))
			m = -m;
		case (kind)
			SIG_EXTREME: begin
				case ($urandom_range(0, 4))
					0: return 24'h7F_FFFF;
					1: return 24'h80_0000;
					2: return 24'h00_0000;
					3: return 24'hFF_FFFF;
					default: return 24'h00_0001;
				endcase
			end
			SIG_QUIET:  return ($urandom_range(0, 15) == 0) ? m : '0;
			SIG_FULL:   return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
			default:    return m;
		endcase
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit, a hang counts as failure
	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

	// sample driver: a new transfer is offered once the previous one went through
	// and its trailing gap has run out; payload changes on the falling edge only
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_taken) begin
				if (in_gap > 0) begin
					in_gap      <= in_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (sample_pend_q.size() > 0) begin
					in_ch.valid  <= 1'b1;
					in_ch.sample <= sample_pend_q[0].sample;
					in_ch.first  <= sample_pend_q[0].first;
					in_ch.last   <= sample_pend_q[0].last;
					in_gap       <= idle_len();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, armed only while samples are still queued so the
	// core fills its output register and then stalls its sample input
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (results_seen >= next_hold_at && sample_pend_q.size() >= 20) begin
			hold_left    <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + HOLD_EVERY;
			hold_cnt     <= hold_cnt + 1;
		end
	end

	// result ready with random short stalls on top of the long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0 || out_stall > 0) begin
				out_ch.ready <= 1'b0;
				if (out_stall > 0)
					out_stall <= out_stall - 1;
			end else begin
				out_ch.ready <= 1'b1;
				out_stall    <= ($urandom_range(0, 3) == 0) ? idle_len() : 0;
			end
		end
	end

	// rising edge: predict each accepted sample, then check each accepted result
	// against the oldest prediction
	always @(posedge clk) begin
		trig_result_t got;
		trig_result_t want;
		in_taken = arst_n && in_ch.valid && in_ch.ready;
		if (in_taken) begin
			ratio_expect_q.push_back(trigger_predict(in_ch.sample, in_ch.first, in_ch.last));
			if (sample_pend_q.size() > 0)
				void'(sample_pend_q.pop_front());
			accepted_cnt++;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.ratio        = out_ch.ratio;
			got.warmed_up    = out_ch.warmed_up;
			got.short_record = out_ch.short_record;
			results_seen++;
			if (ratio_expect_q.size() == 0) begin
				if (mismatch_cnt < 10)
					$display("result %0d arrived with none pending: %s %0d %s %0b %s %0b",
						results_seen, "ratio", got.ratio, "warm", got.warmed_up,
						"short", got.short_record);
				mismatch_cnt++;
			end else begin
				want = ratio_expect_q.pop_front();
				if (want.warmed_up)
					warm_cnt++;
				if (want.short_record)
					short_cnt++;
				if (want.ratio == sltr_pkg::RATIO_CAP)
					sat_cnt++;
				if (got.ratio !== want.ratio || got.warmed_up !== want.warmed_up
					|| got.short_record !== want.short_record) begin
					if (mismatch_cnt < 10)
						$display("result %0d: expected ratio %0d warm %0b short %0b, %s",
							results_seen, want.ratio, want.warmed_up,
							want.short_record, "got");
					if (mismatch_cnt < 10)
						$display("  ratio %0d warm %0b short %0b",
							got.ratio, got.warmed_up, got.short_record);
					mismatch_cnt++;
				end
			end
		end
	end

	task automatic push_sample(logic [SAMPLE_BITS-1:0] s, bit first, bit last);
		sample_item_t it;
		it.sample = s;
		it.first  = first;
		it.last   = last;
		sample_pend_q.push_back(it);
	endtask

	// wait until every queued sample went in and every result came back
	task automatic drain();
		do
			@(negedge clk);
		while (sample_pend_q.size() != 0 || ratio_expect_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// one register write over the configuration channel, only while idle
	task automatic write_reg(logic [sltr_pkg::CFG_IDX_W-1:0] idx,
		logic [sltr_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		if (idx == sltr_pkg::REG_STA_LEN)
			sta_cfg = val;
		else
			lta_cfg = val;
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_windows(logic [sltr_pkg::CFG_W-1:0] s_len,
		logic [sltr_pkg::CFG_W-1:0] l_len);
		if ($urandom_range(0, 1)) begin
			write_reg(sltr_pkg::REG_STA_LEN, s_len);
			write_reg(sltr_pkg::REG_LTA_LEN, l_len);
		end else begin
			write_reg(sltr_pkg::REG_LTA_LEN, l_len);
			write_reg(sltr_pkg::REG_STA_LEN, s_len);
		end
		setting_cnt++;
	endtask

	// random window pair; big_win marks settings whose long window is huge
	task automatic choose_windows(output logic [sltr_pkg::CFG_W-1:0] s_len,
		output logic [sltr_pkg::CFG_W-1:0] l_len, output bit big_win);
		int r;
		r = $urandom_range(0, 99);
		big_win = 0;
		if (r < 70) begin
			l_len = 13'($urandom_range(1, 40));
			s_len = 13'($urandom_range(1, l_len));
		end else if (r < 78) begin
			l_len = 13'($urandom_range(60, 300));
			s_len = 13'($urandom_range(1, l_len));
		end else if (r < 86) begin
			// out-of-range lengths: zero, short longer than long, above the ram depth
			l_len = 13'($urandom_range(0, 40));
			case ($urandom_range(0, 3))
				0: s_len = 13'd0;
				1: s_len = 13'(l_len + $urandom_range(1, 20));
				2: s_len = 13'h1FFF;
				default: s_len = 13'($urandom_range(4097, 8191));
			endcase
		end else if (r < 92) begin
			// huge long window, records stay short of warm-up
			l_len   = $urandom_range(0, 1) ? 13'd4096 : 13'($urandom_range(4097, 8191));
			s_len   = 13'($urandom_range(1, 8191));
			big_win = 1;
		end else begin
			// short window of one sample gives the largest ratios
			l_len = 13'($urandom_range(1, 16));
			s_len = 13'd1;
		end
	endtask

	initial begin
		logic [sltr_pkg::CFG_W-1:0] s_len;
		logic [sltr_pkg::CFG_W-1:0] l_len;
		bit               big_win;
		bit               noisy;
		bit               mid_change;
		bit               big_dummy;
		int               rnd_items;
		int               n_rec;
		int               len;
		int               le;
		int               split;
		int               k;
		int               kk;
		signal_kind_t     kind;
		bit               fl;
		bit               ll;

		// every input known from time zero
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.sample = '0;
		in_ch.first  = 1'b0;
		in_ch.last   = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = sltr_pkg::REG_STA_LEN;
		cfg_ch.data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset windows 50/1000: a short record with extreme samples
		push_sample(24'h7F_FFFF, 1, 0);
		push_sample(24'h80_0000, 0, 0);
		push_sample(24'hFF_FFFF, 0, 0);
		push_sample(24'h00_0000, 0, 1);
		drain();

		// both lengths zero act as one: every sample warm, zero sample gives zero sum
		set_windows(13'd0, 13'd0);
		push_sample(24'h7F_FFFF, 1, 0);
		push_sample(24'h80_0000, 0, 0);
		push_sample(24'h00_0001, 0, 0);
		push_sample(24'h00_0000, 0, 1);
		// new record right after a last, without first
		push_sample(24'h00_0005, 0, 0);
		drain();

		// short window above the long one and above the ram depth; first mid-record
		set_windows(13'h1FFF, 13'd2);
		push_sample(24'h00_0007, 1, 0);
		push_sample(24'hFF_FFF9, 0, 0);
		push_sample(24'h00_0064, 1, 0);
		push_sample(24'h00_0000, 0, 0);
		push_sample(24'h00_0000, 0, 1);
		drain();

		// window growth within a record: short sum wraps below zero, ratio saturates
		set_windows(13'd1, 13'd1);
		push_sample(24'h00_03E8, 1, 0);
		push_sample(24'h00_0000, 0, 0);
		drain();
		set_windows(13'd2, 13'd3);
		push_sample(24'h00_0001, 0, 1);
		drain();

		// largest windows: record ends long before warm-up
		set_windows(13'd4096, 13'd4096);
		push_sample(24'h12_3456, 1, 0);
		push_sample(24'hED_CBA9, 0, 0);
		push_sample(24'h00_0000, 0, 1);
		drain();

		// random phases: new windows, a few records each, random idling or none
		rnd_items = 0;
		while (rnd_items < RANDOM_SAMPLES) begin
			choose_windows(s_len, l_len, big_win);
			set_windows(s_len, l_len);
			no_idle    = ($urandom_range(0, 5) == 0);
			noisy      = ($urandom_range(0, 11) == 0);
			mid_change = ($urandom_range(0, 9) == 0) && !big_win;
			le         = eff_len(l_len);
			n_rec      = (le > 50) ? $urandom_range(1, 2) : $urandom_range(1, 4);
			for (int rec = 0; rec < n_rec; rec++) begin
				if (big_win)
					len = $urandom_range(1, 30);
				else if ($urandom_range(0, 4) == 0)
					len = $urandom_range(1, le);
				else
					len = le + $urandom_range(0, (le < 30) ? 2 * le : 60);
				case ($urandom_range(0, 19))
					0, 1, 2:       kind = SIG_EVENT;
					3, 4:          kind = SIG_EXTREME;
					5, 6:          kind = SIG_QUIET;
					7:             kind = SIG_FULL;
					default:       kind = SIG_NOISE;
				endcase
				k     = $urandom_range(0, SAMPLE_BITS - 1);
				split = (mid_change && rec == 0 && len > 1) ? $urandom_range(1, len - 1) : -1;
				for (int i = 0; i < len; i++) begin
					// change the windows at a random point within a record
					if (i == split) begin
						drain();
						choose_windows(s_len, l_len, big_dummy);
						if (big_dummy)
							l_len = 13'($urandom_range(1, 40));
						set_windows(s_len, l_len);
					end
					// an event lifts the tail of the record well above the background
					kk = (kind == SIG_EVENT && i >= (len * 3) / 4) ? k + 8 : k;
					if (kk > SAMPLE_BITS - 1)
						kk = SAMPLE_BITS - 1;
					fl = (i == 0) && ($urandom_range(0, 6) != 0);
					ll = (i == len - 1);
					// broken sequences: stray first and last flags
					if (noisy) begin
						fl = fl | ($urandom_range(0, 9) == 0);
						ll = ll | ($urandom_range(0, 9) == 0);
					end
					push_sample(rand_sample(kind, kk), fl, ll);
				end
				rnd_items += len;
			end
			drain();
		end

		// trailing wait for anything the core might still emit
		no_idle = 0;
		repeat (60) @(negedge clk);
		if (ratio_expect_q.size() != 0) begin
			$display("%0d expected results never arrived", ratio_expect_q.size());
			mismatch_cnt += ratio_expect_q.size();
		end

		$display("covered %0d samples over %0d window settings (%0d register writes)",
			accepted_cnt, setting_cnt, cfg_writes);
		$display("checked %0d results: %0d warm, %0d short, %0d saturated, %0d hold-offs",
			results_seen, warm_cnt, short_cnt, sat_cnt, hold_cnt);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
